### design/bvm_pkg.sv
package bvm_pkg;

  // Default structure of the averaging window and the warm-up phase
  localparam int DEF_WINDOW_LEN      = 10;
  localparam int DEF_WARMUP_MEASURES = 10;

  // Field widths
  localparam int ADC_W   = 12;
  localparam int MV_W    = 15;
  localparam int PCT_W   = 7;
  localparam int GAIN_W  = 16;
  localparam int IVL_W   = 16;
  localparam int FR_W    = 12;
  localparam int WUC_W   = 4;
  localparam int RAMP_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PCT_NUM_W  = FR_W + PCT_W;  // full range times 100

  // Millivolt thresholds
  localparam logic [MV_W-1:0]   MV_BASE        = 15'd3300;
  localparam logic [MV_W-1:0]   MV_LOW         = 15'd3200;
  localparam logic [MV_W-1:0]   MV_MAX         = 15'd20000;
  localparam logic [MV_W-1:0]   MV_INIT_OFFSET = 15'd60;
  localparam logic [MV_W-1:0]   MV_INIT_LIMIT  = 15'd2000;
  localparam logic [MV_W-1:0]   MV_STEP        = 15'd8;
  localparam logic [RAMP_W-1:0] RAMP_LIMIT     = 8'd200;
  localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_MIN        = 7'd1;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd29621;
  localparam logic [IVL_W-1:0]  RST_WARMUP_IV = 16'd20;
  localparam logic [IVL_W-1:0]  RST_CHARGE_IV = 16'd500;
  localparam logic [IVL_W-1:0]  RST_DISCH_IV  = 16'd1000;
  localparam logic [FR_W-1:0]   RST_FULL_RANGE = 12'd900;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_GAIN    = 3'd0,
    REG_WARMUP_IV     = 3'd1,
    REG_CHARGE_IV     = 3'd2,
    REG_DISCHARGE_IV  = 3'd3,
    REG_FULL_RANGE    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic             charging;
  } in_t;

  typedef struct packed {
    logic             measured;
    logic [MV_W-1:0]  battery_mv;
    logic [MV_W-1:0]  tracked_mv;
    logic [PCT_W-1:0] percent;
    logic             low_battery;
    logic             shutdown_request;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture input beat
    logic step;       // interval count, window shift, warm-up
    logic mul;        // scale window sum
    logic track;      // update tracked voltage
    logic pct_start;  // percent: direct value or launch divider
    logic load_out;   // fill output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic measure;     // this tick produces a measurement
    logic pct_direct;  // percent known without division
    logic div_done;    // divider finishes this cycle
  } st_t;

endpackage

### design/bvm_chan_if.sv
interface bvm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/bvm_ctrl.sv
module bvm_ctrl
  import bvm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COUNT = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_TRACK = 7'b0001000,
    S_PCT   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.step = 1'b1;
        state_d    = st_i.measure ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_TRACK;
      end
      S_TRACK: begin
        cmd_o.track = 1'b1;
        state_d     = S_PCT;
      end
      S_PCT: begin
        cmd_o.pct_start = 1'b1;
        state_d         = st_i.pct_direct ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (st_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/bvm_div.sv
module bvm_div
  import bvm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PCT_NUM_W-1:0] num_i,
  input  logic [FR_W-1:0]      den_i,
  output logic                 done_o,
  output logic [PCT_W-1:0]     quo_o
);

  // Quotient is known to stay below 2**PCT_W: one quotient bit a cycle.
  localparam int CNT_W = $clog2(PCT_W);

  logic                 run_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [PCT_NUM_W-1:0] rem_q;
  logic [PCT_NUM_W-1:0] sd_q;
  logic [PCT_W-1:0]     quo_q;
  logic                 ge;

  assign ge     = (rem_q >= sd_q);
  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = {quo_q[PCT_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(PCT_W - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      sd_q  <= PCT_NUM_W'({den_i, {(PCT_W-1){1'b0}}});
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - sd_q;
      end
      sd_q  <= sd_q >> 1;
      quo_q <= {quo_q[PCT_W-2:0], ge};
    end
  end

endmodule

### design/bvm_dp.sv
module bvm_dp
  import bvm_pkg::*;
#(
  parameter int WINDOW_LEN      = DEF_WINDOW_LEN,
  parameter int WARMUP_MEASURES = DEF_WARMUP_MEASURES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  logic cfg_we_i,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  output st_t  st_o,
  output out_t out_o
);

  localparam int SUM_W  = ADC_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int MVX_W  = (SUM_W > MV_W) ? SUM_W : MV_W;

  // Configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [IVL_W-1:0]  wu_iv_q, ch_iv_q, dis_iv_q;
  logic [FR_W-1:0]   fr_q;

  // Tick state
  logic [ADC_W-1:0]  code_q;
  logic              chg_q;
  logic [IVL_W-1:0]  cnt_q;
  logic [WUC_W-1:0]  wu_cnt_q;
  logic              warm_q;
  logic [ADC_W-1:0]  win_q [WINDOW_LEN];
  logic [SUM_W-1:0]  sum_q;
  logic [MV_W-1:0]   trk_q;
  logic [RAMP_W-1:0] rc_q;
  logic [PCT_W-1:0]  lp_q;
  logic              meas_q;
  logic [PROD_W-1:0] prod_q;
  logic [MV_W-1:0]   mv_q;
  out_t              out_q;

  // Interval and warm-up decisions
  logic [IVL_W-1:0] cnt_dec, cnt_reload;
  logic             hit, skip;

  assign cnt_dec    = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
  assign hit        = (cnt_dec == '0);
  assign skip       = !warm_q && (wu_cnt_q < WUC_W'(WARMUP_MEASURES));
  assign cnt_reload = !warm_q ? wu_iv_q : (chg_q ? ch_iv_q : dis_iv_q);

  // Scaling with saturation
  logic [MVX_W-1:0] mv_full;
  logic [MV_W-1:0]  mv;

  assign mv_full = MVX_W'(prod_q[PROD_W-1:GAIN_W]);
  assign mv      = (mv_full > MVX_W'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];

  // Tracking filter
  logic [MV_W-1:0]   trk_d, t1;
  logic [RAMP_W-1:0] rc_d, rc_inc;
  logic [MV_W:0]     t1_step;

  always_comb begin
    trk_d   = trk_q;
    rc_d    = rc_q;
    t1      = trk_q;
    t1_step = '0;
    rc_inc  = rc_q + 1'b1;
    if (chg_q) begin
      if (mv > trk_q) begin
        if (trk_q < MV_INIT_LIMIT) begin
          t1 = (mv > MV_INIT_OFFSET) ? mv - MV_INIT_OFFSET : '0;
        end
        t1_step = {1'b0, t1} + {1'b0, MV_STEP};
        trk_d   = t1;
        if ({1'b0, mv} >= t1_step) begin
          if (rc_inc > RAMP_LIMIT) begin
            rc_d  = '0;
            trk_d = t1_step[MV_W-1:0];
          end else begin
            rc_d = rc_inc;
          end
        end
      end
    end else begin
      rc_d = '0;
      if (trk_q == '0 || mv < trk_q) begin
        trk_d = mv;
      end
    end
  end

  // Percent of range
  logic [MV_W-1:0]      pct_d_mv;
  logic                 pct_direct;
  logic [PCT_W-1:0]     pct_direct_val;
  logic [PCT_NUM_W-1:0] pct_num;
  logic                 div_start, div_done;
  logic [PCT_W-1:0]     div_quo;

  assign pct_d_mv = trk_q - MV_BASE;
  always_comb begin
    pct_direct     = 1'b0;
    pct_direct_val = PCT_MIN;
    if (trk_q < MV_BASE) begin
      pct_direct     = 1'b1;
      pct_direct_val = PCT_MIN;
    end else if (fr_q == '0 || pct_d_mv > MV_W'(fr_q)) begin
      pct_direct     = 1'b1;
      pct_direct_val = PCT_FULL;
    end
  end

  assign pct_num   = PCT_NUM_W'(pct_d_mv[FR_W-1:0]) * PCT_NUM_W'(PCT_FULL);
  assign div_start = cmd_i.pct_start && !pct_direct;

  bvm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pct_num),
    .den_i   (fr_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign st_o.measure    = hit && !skip;
  assign st_o.pct_direct = pct_direct;
  assign st_o.div_done   = div_done;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= RST_GAIN;
      wu_iv_q  <= RST_WARMUP_IV;
      ch_iv_q  <= RST_CHARGE_IV;
      dis_iv_q <= RST_DISCH_IV;
      fr_q     <= RST_FULL_RANGE;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        REG_SCALE_GAIN:   gain_q   <= cfg_i.data;
        REG_WARMUP_IV:    wu_iv_q  <= cfg_i.data;
        REG_CHARGE_IV:    ch_iv_q  <= cfg_i.data;
        REG_DISCHARGE_IV: dis_iv_q <= cfg_i.data;
        REG_FULL_RANGE:   fr_q     <= cfg_i.data[FR_W-1:0];
        default: ;
      endcase
    end
  end

  // Measurement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wu_cnt_q <= '0;
      warm_q   <= 1'b0;
      sum_q    <= '0;
      trk_q    <= '0;
      rc_q     <= '0;
      lp_q     <= '0;
      meas_q   <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cmd_i.step) begin
        meas_q <= hit && !skip;
        cnt_q  <= hit ? cnt_reload : cnt_dec;
        if (hit) begin
          // advance the window, drop the oldest code from the sum
          sum_q    <= sum_q + SUM_W'(code_q) - SUM_W'(win_q[WINDOW_LEN-1]);
          win_q[0] <= code_q;
          for (int i = 1; i < WINDOW_LEN; i++) begin
            win_q[i] <= win_q[i-1];
          end
          if (skip) begin
            wu_cnt_q <= wu_cnt_q + 1'b1;
          end else if (!warm_q) begin
            warm_q   <= 1'b1;
            wu_cnt_q <= '0;
          end
        end
      end
      if (cmd_i.track) begin
        trk_q <= trk_d;
        rc_q  <= rc_d;
      end
      if (cmd_i.pct_start && pct_direct) begin
        lp_q <= pct_direct_val;
      end else if (div_done) begin
        lp_q <= (div_quo == '0) ? PCT_MIN : div_quo;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      code_q <= in_i.adc_sample;
      chg_q  <= in_i.charging;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(gain_q);
    end
    if (cmd_i.track) begin
      mv_q <= mv;
    end
    if (cmd_i.load_out) begin
      out_q.measured         <= meas_q;
      out_q.battery_mv       <= meas_q ? mv_q : '0;
      out_q.tracked_mv       <= trk_q;
      out_q.percent          <= lp_q;
      out_q.low_battery      <= meas_q && (mv_q < MV_LOW);
      out_q.shutdown_request <= meas_q && (mv_q < MV_LOW) && !chg_q;
    end
  end

  assign out_o = out_q;

endmodule

### design/battery_voltage_monitor_unit.sv
// Battery voltage monitor.
// in_i carries one timer tick per beat: the newest 12-bit converter code and
// the charger flag. out_o returns exactly one result beat per tick: measured,
// battery_mv, tracked_mv, percent, low_battery and shutdown_request. cfg_i
// writes the gain, the three measurement intervals and the full-range span;
// it is always ready. The user must write it only while no tick is in flight;
// the block itself does not enforce this. A tick that only counts down goes
// from the idle state through the count state to the done state, which
// waits for a free output register and then loads it. A measuring tick goes
// through window shift, one registered multiply, the tracking filter, then
// the percent step, where the figure is set directly or by a restoring
// divider (one quotient bit a cycle). One tick is worked at a time; in_i is
// ready again the cycle after the result is parked in the output register.
// Reset clears the window, the sum, all counters and the tracked voltage and
// loads the register defaults; no clearing pass is needed.
// When the receiver stalls, the output register holds its beat; the block
// still accepts one more tick and finishes it, then waits to load its result.
module battery_voltage_monitor_unit
  import bvm_pkg::*;
#(
  parameter int WINDOW_LEN      = DEF_WINDOW_LEN,
  parameter int WARMUP_MEASURES = DEF_WARMUP_MEASURES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bvm_chan_if.sink   in_i,
  bvm_chan_if.sink   cfg_i,
  bvm_chan_if.source out_o
);

  cmd_t cmd;
  st_t  st;
  logic in_ready;
  logic out_valid;
  logic cfg_we;
  out_t out_data;

  // Config writes are always accepted and go straight into the registers
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_data;

  bvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  bvm_dp #(
    .WINDOW_LEN      (WINDOW_LEN),
    .WARMUP_MEASURES (WARMUP_MEASURES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i.payload),
    .cfg_we_i (cfg_we),
    .cfg_i    (cfg_i.payload),
    .cmd_i    (cmd),
    .st_o     (st),
    .out_o    (out_data)
  );

  // One tick in flight: an accepted beat closes the input until it is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while a tick is still in flight");

  // A new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_o.valid && !out_o.ready))
    else $error("output register overwritten while stalled");

  // A tick without a measurement reports no voltage and no alarm
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.payload.measured |->
      out_o.payload.battery_mv == '0 && !out_o.payload.low_battery &&
      !out_o.payload.shutdown_request)
    else $error("voltage or alarm reported without a measurement");

  // Divider only finishes inside a measuring tick, never with input open
  a_div_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.div_done |-> !in_i.ready)
    else $error("divider finished while the block was idle");

endmodule

### bench/tb_battery_voltage_monitor_unit.sv
module tb_battery_voltage_monitor_unit import bvm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the monitor: registers, window, counters and tracked voltage,
  // plus the queue of result beats each accepted tick is due to produce.
  class bvm_tick_scoreboard;
    logic [GAIN_W-1:0] gain;
    logic [IVL_W-1:0]  warmup_iv;
    logic [IVL_W-1:0]  charge_iv;
    logic [IVL_W-1:0]  discharge_iv;
    logic [FR_W-1:0]   full_range;
    int unsigned window[DEF_WINDOW_LEN];
    int unsigned ticks_left;
    int unsigned warmups;
    bit          warmed;
    int unsigned tracked;
    int unsigned ramp;
    int unsigned last_pct;
    out_t        due_results_q[$];
    int unsigned errors;

    function new();
      gain         = RST_GAIN;
      warmup_iv    = RST_WARMUP_IV;
      charge_iv    = RST_CHARGE_IV;
      discharge_iv = RST_DISCH_IV;
      full_range   = RST_FULL_RANGE;
      foreach (window[i]) window[i] = 0;
      ticks_left = 0;
      warmups    = 0;
      warmed     = 1'b0;
      tracked    = 0;
      ramp       = 0;
      last_pct   = 0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SCALE_GAIN:   gain = v;
        REG_WARMUP_IV:    warmup_iv = v;
        REG_CHARGE_IV:    charge_iv = v;
        REG_DISCHARGE_IV: discharge_iv = v;
        REG_FULL_RANGE:   full_range = v[FR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned charge_percent(int unsigned mv);
      int unsigned d;
      int unsigned p;
      if (mv < MV_BASE) return PCT_MIN;
      d = mv - MV_BASE;
      if (full_range == 0 || d > full_range) return PCT_FULL;
      p = d * 100 / full_range;
      return (p < PCT_MIN) ? PCT_MIN : p;
    endfunction

    function void note_tick(in_t t);
      out_t            r;
      bit              take;
      int unsigned     sum;
      int unsigned     mv;
      longint unsigned scaled;
      r = '0;
      r.tracked_mv = tracked[MV_W-1:0];
      r.percent    = last_pct[PCT_W-1:0];
      if (ticks_left != 0) ticks_left--;
      take = (ticks_left == 0);
      if (take) begin
        ticks_left = !warmed ? warmup_iv : (t.charging ? charge_iv : discharge_iv);
        sum = t.adc_sample;
        for (int i = DEF_WINDOW_LEN - 1; i > 0; i--) begin
          window[i] = window[i-1];
          sum += window[i];
        end
        window[0] = t.adc_sample;
        if (!warmed) begin
          if (warmups < DEF_WARMUP_MEASURES) begin
            warmups++;
            take = 1'b0;
          end else begin
            warmed  = 1'b1;
            warmups = 0;
          end
        end
      end
      if (take) begin
        scaled = (64'(sum) * 64'(gain)) >> 16;
        mv = (scaled > MV_MAX) ? MV_MAX : 32'(scaled);
        if (t.charging) begin
          if (mv > tracked) begin
            if (tracked < MV_INIT_LIMIT)
              tracked = (mv > MV_INIT_OFFSET) ? mv - MV_INIT_OFFSET : 0;
            if (mv >= tracked + MV_STEP) begin
              ramp++;
              if (ramp > RAMP_LIMIT) begin
                ramp = 0;
                tracked += MV_STEP;
              end
            end
          end
        end else begin
          ramp = 0;
          if (tracked == 0 || mv < tracked) tracked = mv;
        end
        last_pct = charge_percent(tracked);
        r.measured         = 1'b1;
        r.battery_mv       = mv[MV_W-1:0];
        r.tracked_mv       = tracked[MV_W-1:0];
        r.percent          = last_pct[PCT_W-1:0];
        r.low_battery      = (mv < MV_LOW);
        r.shutdown_request = (mv < MV_LOW) && !t.charging;
      end
      due_results_q.push_back(r);
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results_q.size() == 0) begin
        $error("result beat with no tick outstanding");
        errors++;
        return;
      end
      want = due_results_q.pop_front();
      check_field("measured", 16'(want.measured), 16'(got.measured));
      check_field("battery_mv", 16'(want.battery_mv), 16'(got.battery_mv));
      check_field("tracked_mv", 16'(want.tracked_mv), 16'(got.tracked_mv));
      check_field("percent", 16'(want.percent), 16'(got.percent));
      check_field("low_battery", 16'(want.low_battery), 16'(got.low_battery));
      check_field("shutdown_request", 16'(want.shutdown_request),
                  16'(got.shutdown_request));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bvm_chan_if #(.payload_t(in_t))  tick_if ();
  bvm_chan_if #(.payload_t(cfg_t)) cfg_if ();
  bvm_chan_if #(.payload_t(out_t)) res_if ();

  battery_voltage_monitor_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .cfg_i  (cfg_if),
    .out_o  (res_if)
  );

  bvm_tick_scoreboard sb;

  // Knobs for the tick driver and the result sink.
  bit          quiet = 1'b0;        // last phase: no idling on either side
  bit          hold_pending = 1'b0; // ask the sink for one long hold-off
  int unsigned tx_gap_pct = 0;      // chance of a gap burst after a tick beat
  int unsigned rx_stall_pct = 0;    // chance of a stall burst per cycle
  int unsigned rx_wait;

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs; sized for several times the slowest
  // legal run.
  initial begin
    #5_000_000;
    $display("[battery_voltage_monitor_unit] ERROR");
    $finish;
  end

  // Result sink: decide ready at each falling edge. A stall burst drops ready
  // at random; a hold-off request drops it so that the output register and
  // the tick in flight back up and in_i stalls.
  initial begin
    res_if.ready = 1'b0;
    rx_wait = 0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) begin
        rx_wait--;
      end else if (hold_pending) begin
        rx_wait = 400;
        hold_pending = 1'b0;
      end else if (!quiet && $urandom_range(99, 0) < rx_stall_pct) begin
        rx_wait = $urandom_range(17, 1);
      end
      res_if.ready <= (rx_wait == 0);
    end
  end

  // Check every accepted result beat against the oldest due result.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result(res_if.payload);
  end

  // Drop valid now and keep it low until the task returns.
  task automatic idle_ticks(int unsigned n);
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Offer one tick beat, wait for the handshake, then predict its result.
  // Valid stays high into the next tick unless a gap burst is drawn.
  task automatic send_tick(logic [ADC_W-1:0] code, logic chg);
    in_t t;
    t.adc_sample = code;
    t.charging   = chg;
    @(negedge clk_i);
    tick_if.valid   <= 1'b1;
    tick_if.payload <= t;
    do @(posedge clk_i); while (tick_if.ready !== 1'b1);
    sb.note_tick(t);
    if (!quiet && $urandom_range(99, 0) < tx_gap_pct)
      idle_ticks($urandom_range(17, 1));
  endtask

  // Write one register; only called while no tick is in flight.
  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_t w;
    w.index = idx;
    w.data  = v;
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_config(logic [15:0] g, logic [15:0] wu, logic [15:0] ch,
                             logic [15:0] dis, logic [FR_W-1:0] fr);
    write_reg(REG_SCALE_GAIN, g);
    write_reg(REG_WARMUP_IV, wu);
    write_reg(REG_CHARGE_IV, ch);
    write_reg(REG_DISCHARGE_IV, dis);
    write_reg(REG_FULL_RANGE, 16'(fr));
  endtask

  // Stop offering ticks, wait for every due result, then let the block's
  // longest tick latency run out before anything else happens.
  task automatic settle();
    int unsigned guard;
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    guard = 0;
    while (sb.due_results_q.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.due_results_q.size() != 0) begin
      $error("%0d tick results never arrived", sb.due_results_q.size());
      sb.errors++;
      sb.due_results_q.delete();
    end
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    int unsigned      n;
    int unsigned      level;
    logic [ADC_W-1:0] code;
    logic             chg;
    logic [15:0]      g;
    logic [FR_W-1:0]  fr;

    sb = new();
    rst_ni          = 1'b0;
    tick_if.valid   = 1'b0;
    tick_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part. Zero warm-up and charge intervals and a unit discharge
    // interval make every tick take a sample; gain and full range keep their reset values for now.
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    write_reg(REG_WARMUP_IV, 16'd0);
    write_reg(REG_CHARGE_IV, 16'd0);
    write_reg(REG_DISCHARGE_IV, 16'd1);

    // Warm-up: ten skipped measurements, the eleventh reports.
    for (int i = 0; i < 11; i++)
      send_tick((i % 2) ? 12'hFFF : 12'h000, i[0]);
    send_tick(12'hFFF, 1'b0);
    send_tick(12'h000, 1'b1);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'h000, 1'b0);
    send_tick(12'hAAA, 1'b0);
    send_tick(12'h555, 1'b1);

    // Full gain saturates the voltage; zero full range pins percent at 100.
    settle();
    write_reg(REG_SCALE_GAIN, 16'hFFFF);
    write_reg(REG_FULL_RANGE, 16'd0);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'hFFF, 1'b1);
    send_tick(12'hFFF, 1'b0);

    // Zero gain: 0 mV, low battery, and shutdown once discharging; this also
    // pulls the tracked voltage back to zero for the first charge ramp.
    settle();
    write_reg(REG_SCALE_GAIN, 16'd0);
    write_reg(REG_FULL_RANGE, 16'(12'hFFF));
    send_tick(12'd800, 1'b0);
    send_tick(12'd800, 1'b1);

    // Random phases, cycling through three kinds of traffic:
    //   charge ramp: long charging stretch near one level, every tick
    //     measuring, so the ramp counter passes its limit; breaks late on
    //   slow discharge: falling level, mostly not charging
    //   raw noise: any code, any charger flag
    for (int p = 0; p < 9; p++) begin
      settle();
      quiet = (p == 8);
      case ($urandom_range(2, 0))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 8;
        default: tx_gap_pct = 30;
      endcase
      case ($urandom_range(2, 0))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 8;
        default: rx_stall_pct = 30;
      endcase
      g = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(31621, 27621));
      case ($urandom_range(3, 0))
        0: fr = 12'd900;
        1: fr = 12'd1;
        2: fr = 12'hFFF;
        default: fr = 12'($urandom_range(4095, 1));
      endcase
      load_config(g, (p == 7) ? 16'hFFFF : 16'($urandom_range(5, 0)),
                  (p % 3 == 0) ? 16'($urandom_range(1, 0)) : 16'($urandom_range(3, 0)),
                  16'($urandom_range(4, 0)), fr);
      if (p == 4) hold_pending = 1'b1;
      level = $urandom_range(1000, 650);
      n = (p % 3 == 0) ? 260 : 70;
      for (int k = 0; k < n; k++) begin
        case (p % 3)
          0: begin
            code = 12'(level + $urandom_range(7, 0));
            chg  = (k < 220) ? 1'b1 : ($urandom_range(3, 0) != 0);
          end
          1: begin
            if ($urandom_range(3, 0) == 0 && level > 500) level--;
            code = 12'(level + $urandom_range(15, 0));
            chg  = ($urandom_range(29, 0) == 0);
          end
          default: begin
            code = 12'($urandom);
            chg  = 1'($urandom);
          end
        endcase
        send_tick(code, chg);
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("[battery_voltage_monitor_unit] OK");
    end else begin
      $display("[battery_voltage_monitor_unit] ERROR");
    end
    $finish;
  end

endmodule
